### design/bsc_pkg.sv
// Shared types and codes for the bytecode stack calculator.
// Used by the controller, the datapath, the multiply/divide unit and the top level.
`default_nettype none
package bsc_pkg;

    // command codes (tuser on the input side)
    localparam logic [2:0] CMD_RET   = 3'd0;
    localparam logic [2:0] CMD_CONST = 3'd1;
    localparam logic [2:0] CMD_NEG   = 3'd2;
    localparam logic [2:0] CMD_ADD   = 3'd3;
    localparam logic [2:0] CMD_SUB   = 3'd4;
    localparam logic [2:0] CMD_MUL   = 3'd5;
    localparam logic [2:0] CMD_DIV   = 3'd6;

    // status codes (tuser on the output side)
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_RET   = 3'd1;
    localparam logic [2:0] ST_UNDER = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_DIV0  = 3'd4;
    localparam logic [2:0] ST_SAT   = 3'd5;

    localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

    localparam int DEPTH_FIELD_W = 9;
    localparam int IN_TDATA_W    = 64;
    localparam int OUT_TDATA_W   = 80;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_DECODE,
        CS_READ,
        CS_MDWAIT,
        CS_COMMIT
    } ctl_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV,
        MD_FIN
    } md_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic mem_rd;
        logic md_start;
        logic commit;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       sp_ge2;
        logic       out_free;
        logic       md_done;
    } ctl_stat_t;

    function automatic logic is_binary(input logic [2:0] cmd);
        return (cmd == CMD_ADD) || (cmd == CMD_SUB) || (cmd == CMD_MUL) || (cmd == CMD_DIV);
    endfunction

endpackage
`default_nettype wire

### design/bsc_muldiv.sv
// Iterative Q32.32 multiply (four 32x32 partial products) and divide (restoring, 1 bit/cycle).
// Depends on bsc_pkg.
`default_nettype none
module bsc_muldiv
    import bsc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic        is_div,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             done,
    output logic [63:0]      res,
    output logic             sat,
    output logic             dz
);

    md_state_t state_reg, state_next;

    logic         neg_reg, aneg_reg, div_reg, dz_reg, over_reg;
    logic [63:0]  ua_reg, ub_reg, pp_reg, rem_reg, q_reg, res_reg;
    logic [127:0] acc_reg;
    logic [95:0]  dvd_reg;
    logic [6:0]   cnt_reg;
    logic         sat_reg, done_reg;

    logic [63:0]  ua_in, ub_in;
    logic [31:0]  a_half, b_half;
    logic [127:0] pp_shift, prod;
    logic [63:0]  rem_sh, mul_r;
    logic         rem_ge;
    logic [6:0]   cnt_prev;

    assign ua_in = a[63] ? (64'd0 - a) : a;
    assign ub_in = b[63] ? (64'd0 - b) : b;

    assign a_half = cnt_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
    assign b_half = cnt_reg[0] ? ub_reg[63:32] : ub_reg[31:0];

    assign cnt_prev = cnt_reg - 7'd1;
    always_comb begin
        case (cnt_prev[1:0])
            2'd0:    pp_shift = {64'd0, pp_reg};
            2'd3:    pp_shift = {pp_reg, 64'd0};
            default: pp_shift = {32'd0, pp_reg, 32'd0};
        endcase
    end

    assign rem_sh = {rem_reg[62:0], dvd_reg[95]};
    assign rem_ge = (rem_sh >= ub_reg);

    assign prod  = neg_reg ? (128'd0 - acc_reg) : acc_reg;
    assign mul_r = prod[95:32];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            MD_IDLE: begin
                if (start) begin
                    if (!is_div)       state_next = MD_MUL;
                    else if (b == '0)  state_next = MD_FIN;
                    else               state_next = MD_DIV;
                end
            end
            MD_MUL:  if (cnt_reg == 7'd4) state_next = MD_FIN;
            MD_DIV:  if (cnt_reg == 7'd95) state_next = MD_FIN;
            MD_FIN:  state_next = MD_IDLE;
            default: state_next = MD_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == MD_FIN);
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            MD_IDLE: begin
                if (start) begin
                    neg_reg  <= a[63] ^ b[63];
                    aneg_reg <= a[63];
                    div_reg  <= is_div;
                    dz_reg   <= is_div && (b == '0);
                    ua_reg   <= ua_in;
                    ub_reg   <= ub_in;
                    acc_reg  <= '0;
                    rem_reg  <= '0;
                    q_reg    <= '0;
                    over_reg <= 1'b0;
                    dvd_reg  <= {ua_in, 32'd0};
                    cnt_reg  <= '0;
                end
            end
            MD_MUL: begin
                pp_reg <= a_half * b_half;
                if (cnt_reg != 7'd0) acc_reg <= acc_reg + pp_shift;
                cnt_reg <= cnt_reg + 7'd1;
            end
            MD_DIV: begin
                rem_reg  <= rem_ge ? (rem_sh - ub_reg) : rem_sh;
                q_reg    <= {q_reg[62:0], rem_ge};
                over_reg <= over_reg | q_reg[63];
                dvd_reg  <= {dvd_reg[94:0], 1'b0};
                cnt_reg  <= cnt_reg + 7'd1;
            end
            MD_FIN: begin
                sat_reg <= 1'b0;
                if (dz_reg) begin
                    res_reg <= aneg_reg ? Q_MIN : Q_MAX;
                end else if (div_reg) begin
                    if (neg_reg) begin
                        if (over_reg || (q_reg > Q_MIN)) begin
                            res_reg <= Q_MIN;
                            sat_reg <= 1'b1;
                        end else begin
                            res_reg <= 64'd0 - q_reg;
                        end
                    end else if (over_reg || (q_reg > Q_MAX)) begin
                        res_reg <= Q_MAX;
                        sat_reg <= 1'b1;
                    end else begin
                        res_reg <= q_reg;
                    end
                end else if (prod[127:96] != {32{mul_r[63]}}) begin
                    res_reg <= neg_reg ? Q_MIN : Q_MAX;
                    sat_reg <= 1'b1;
                end else begin
                    res_reg <= mul_r;
                end
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign res  = res_reg;
    assign sat  = sat_reg;
    assign dz   = dz_reg;

endmodule
`default_nettype wire

### design/bsc_dp.sv
// Datapath: operand stack memory, cached top entry, add/sub/negate, output register.
// Depends on bsc_pkg and bsc_muldiv.
`default_nettype none
module bsc_dp
    import bsc_pkg::*;
#(
    parameter int STACK_DEPTH = 256
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire ctl_cmd_t                ctl,
    output ctl_stat_t                    stat,
    input  wire logic [2:0]              in_cmd,
    input  wire logic [63:0]             in_const,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [2:0]                   out_status,
    output logic [63:0]                  out_top,
    output logic [DEPTH_FIELD_W-1:0]     out_depth
);

    localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

    // entries below the top one; the top is held in top_reg
    logic [63:0] mem [STACK_DEPTH];

    logic [2:0]     cmd_reg;
    logic [63:0]    const_reg, top_reg, top_next, rd_reg;
    logic [SPW-1:0] sp_reg, sp_next, sp_m1, sp_m2;
    logic           sp_nz, sp_ge2, mem_we;

    logic        out_valid_reg;
    logic [2:0]  out_status_reg, st_next;
    logic [63:0] out_top_reg, ot_next;
    logic [DEPTH_FIELD_W-1:0] out_depth_reg;

    logic [63:0] a_op, b_op, sum, dif, negv, bin_r;
    logic        add_ovf, sub_ovf;
    logic [2:0]  bin_st;

    logic        md_done, md_sat, md_dz;
    logic [63:0] md_res;

    assign sp_m1  = sp_reg - SPW'(1);
    assign sp_m2  = sp_reg - SPW'(2);
    assign sp_nz  = (sp_reg != '0);
    assign sp_ge2 = (sp_reg >= SPW'(2));

    assign a_op = rd_reg;
    assign b_op = top_reg;
    assign sum  = a_op + b_op;
    assign dif  = a_op - b_op;
    assign add_ovf = (a_op[63] ^ sum[63]) & (b_op[63] ^ sum[63]);
    assign sub_ovf = (a_op[63] ^ b_op[63]) & (a_op[63] ^ dif[63]);
    assign negv = (top_reg == Q_MIN) ? Q_MAX : (64'd0 - top_reg);

    bsc_muldiv u_md (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctl.md_start),
        .is_div  (cmd_reg == CMD_DIV),
        .a       (a_op),
        .b       (b_op),
        .done    (md_done),
        .res     (md_res),
        .sat     (md_sat),
        .dz      (md_dz)
    );

    always_comb begin
        bin_r  = md_res;
        bin_st = md_dz ? ST_DIV0 : (md_sat ? ST_SAT : ST_OK);
        case (cmd_reg)
            CMD_ADD: begin
                bin_r  = add_ovf ? (a_op[63] ? Q_MIN : Q_MAX) : sum;
                bin_st = add_ovf ? ST_SAT : ST_OK;
            end
            CMD_SUB: begin
                bin_r  = sub_ovf ? (a_op[63] ? Q_MIN : Q_MAX) : dif;
                bin_st = sub_ovf ? ST_SAT : ST_OK;
            end
            default: ;
        endcase
    end

    always_comb begin
        sp_next  = sp_reg;
        top_next = top_reg;
        st_next  = ST_OK;
        ot_next  = sp_nz ? top_reg : 64'd0;
        mem_we   = 1'b0;
        case (cmd_reg)
            CMD_RET: begin
                if (!sp_nz) begin
                    st_next = ST_UNDER;
                end else begin
                    st_next  = ST_RET;
                    ot_next  = top_reg;
                    sp_next  = sp_m1;
                    top_next = rd_reg;
                end
            end
            CMD_CONST: begin
                if (sp_reg == SP_FULL) begin
                    st_next = ST_FULL;
                end else begin
                    mem_we   = sp_nz;
                    top_next = const_reg;
                    sp_next  = sp_reg + SPW'(1);
                    ot_next  = const_reg;
                end
            end
            CMD_NEG: begin
                if (!sp_nz) begin
                    st_next = ST_UNDER;
                end else begin
                    top_next = negv;
                    ot_next  = negv;
                    st_next  = (top_reg == Q_MIN) ? ST_SAT : ST_OK;
                end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                if (!sp_ge2) begin
                    st_next = ST_UNDER;
                end else begin
                    top_next = bin_r;
                    ot_next  = bin_r;
                    sp_next  = sp_m1;
                    st_next  = bin_st;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_in) begin
            cmd_reg   <= in_cmd;
            const_reg <= in_const;
        end
        if (ctl.mem_rd) rd_reg <= mem[sp_m2[AW-1:0]];
        if (ctl.commit && mem_we) mem[sp_m1[AW-1:0]] <= top_reg;
        if (ctl.commit) begin
            top_reg        <= top_next;
            out_status_reg <= st_next;
            out_top_reg    <= ot_next;
            out_depth_reg  <= DEPTH_FIELD_W'(sp_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ctl.commit) sp_reg <= sp_next;
            if (ctl.commit)         out_valid_reg <= 1'b1;
            else if (out_ready)     out_valid_reg <= 1'b0;
        end
    end

    assign stat.cmd      = cmd_reg;
    assign stat.sp_ge2   = sp_ge2;
    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.md_done  = md_done;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_top    = out_top_reg;
    assign out_depth  = out_depth_reg;

endmodule
`default_nettype wire

### design/bsc_ctrl.sv
// Controller: sequences one instruction through decode, stack read, mul/div and commit.
// Depends on bsc_pkg.
`default_nettype none
module bsc_ctrl
    import bsc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire ctl_stat_t stat,
    output ctl_cmd_t       ctl
);

    ctl_state_t state_reg, state_next;
    logic needs_read, is_md;

    assign needs_read = ((stat.cmd == CMD_RET) || is_binary(stat.cmd)) && stat.sp_ge2;
    assign is_md      = (stat.cmd == CMD_MUL) || (stat.cmd == CMD_DIV);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:   if (in_valid) state_next = CS_DECODE;
            CS_DECODE: state_next = needs_read ? CS_READ : CS_COMMIT;
            CS_READ:   state_next = is_md ? CS_MDWAIT : CS_COMMIT;
            CS_MDWAIT: if (stat.md_done) state_next = CS_COMMIT;
            CS_COMMIT: if (stat.out_free) state_next = CS_IDLE;
            default:   state_next = CS_IDLE;
        endcase
    end

    always_comb begin
        in_ready     = 1'b0;
        ctl          = '0;
        unique case (state_reg)
            CS_IDLE: begin
                in_ready    = 1'b1;
                ctl.load_in = in_valid;
            end
            CS_DECODE: ctl.mem_rd   = needs_read;
            CS_READ:   ctl.md_start = is_md;
            CS_MDWAIT: ;
            CS_COMMIT: ctl.commit   = stat.out_free;
            default:   ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= CS_IDLE;
        else          state_reg <= state_next;
    end

endmodule
`default_nettype wire

### design/bytecode_stack_calculator.sv
// Bytecode stack calculator, Q32.32 operand stack. Depends on bsc_pkg, bsc_ctrl, bsc_dp.
// Constant, negate, unused code, underflow and return of the last entry go from decode
// straight to commit; add, subtract and other returns read the stack first; multiply (four
// 32x32 partial products) and divide (96 steps) then wait for the mul/div unit, which
// ends divide by zero without iterating. One instruction in flight; the next transaction
// is taken the cycle after the result is registered, even while that result waits.
// Synchronous active-low reset empties the stack and clears the output valid.
`default_nettype none
module bytecode_stack_calculator
    import bsc_pkg::*;
#(
    parameter int STACK_DEPTH = 256
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [63:0] constant_value
    input  wire logic [2:0]             s_axis_tuser,   // [2:0] command
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [63:0] top_value, [72:64] depth_now
    output logic [2:0]                  m_axis_tuser    // [2:0] status
);

    ctl_cmd_t  ctl;
    ctl_stat_t stat;
    logic [63:0] top_value;
    logic [DEPTH_FIELD_W-1:0] depth_now;

    bsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    bsc_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .stat       (stat),
        .in_cmd     (s_axis_tuser),
        .in_const   (s_axis_tdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_top    (top_value),
        .out_depth  (depth_now)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - 64 - DEPTH_FIELD_W)'(0), depth_now, top_value};

endmodule
`default_nettype wire

### design/bsc_checker.sv
// Port-level checks for the bytecode stack calculator, bound to the top level.
// Depends on bsc_pkg.
`default_nettype none
module bsc_checker
    import bsc_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [2:0]             m_axis_tuser
);

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tuser <= ST_SAT)
        else $error("undefined status code");

    a_under_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == ST_UNDER |-> m_axis_tdata[72:64] < 9'd2)
        else $error("underflow reported with two or more entries");

    a_ret_not_full_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("two inputs taken back to back");

endmodule

bind bytecode_stack_calculator bsc_checker u_bsc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
